// File: rtl/core/brf_pkg.sv
// shared types, constants and the crc update for the block-acked file receiver
package brf_pkg;

  // queue depth default for the result queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // reset value of the ack byte register
  localparam logic [7:0] ACK_CHAR_RESET = 8'd10;

  // crc-16/ccitt constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // input command codes
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_STORE   = 3'd0,
    KIND_ACK     = 3'd1,
    KIND_OK      = 3'd2,
    KIND_CHKERR  = 3'd3,
    KIND_CRCERR  = 3'd4,
    KIND_TIMEOUT = 3'd5,
    KIND_ZEROBLK = 3'd6
  } kind_t;

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] len;
  } res_t;

  // all results caused by one input item (one or two)
  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // msb-first crc-16 update over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/block_acked_file_receiver_crc16.sv
// top level of the block-acked file receiver with crc-16 check
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    cmd, rx_byte
//  out      output     out_valid / out_ready  out_kind, out_byte, file_length, out_last
//  cfg      input      cfg_valid / cfg_ready  cfg_data (ack byte)
//
// one input item is taken per cycle while the result queue is not full; header,
// data and crc work for a byte is done in the cycle it is accepted. each item gives
// up to two results; the back end plays out one result per cycle while out_ready
// is high. the result queue (QUEUE_DEPTH entries) absorbs output stalls; in_ready
// drops only when it is full. reset is synchronous and leaves the receiver idle.
module block_acked_file_receiver_crc16 #(
  parameter int QUEUE_DEPTH = brf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [31:0] file_length,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import brf_pkg::*;

  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    head;
  q_status_t q_status;

  // command parsing and crc
  brf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .rx_byte    (rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // result queue
  brf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // output stage
  brf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .file_length (file_length),
    .out_last    (out_last)
  );

`ifndef SYNTH
  // first of a result pair is always a stored data byte
  a_pair_first_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_kind == KIND_STORE)
    else $error("non-last result is not a store byte");

  // only the ack carries a file length
  a_len_on_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_ACK |-> file_length == 32'd0)
    else $error("file length outside an ack");

  // status results end an item and carry no byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_OK || out_kind == KIND_CRCERR ||
      out_kind == KIND_CHKERR || out_kind == KIND_TIMEOUT ||
      out_kind == KIND_ZEROBLK) |-> out_last && out_byte == 8'd0)
    else $error("status result not last or has a byte");

  // output slot only fills from a non-empty queue
  a_fill_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!q_status.empty))
    else $error("output valid without a queued entry");
`endif

endmodule

// File: rtl/core/brf_front.sv
// front end: parses commands, tracks header and data phases, runs the crc
module brf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      cmd,
  input  logic [7:0]      rx_byte,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data,
  input  brf_pkg::q_status_t q_status,
  output logic            push,
  output brf_pkg::entry_t push_entry
);
  import brf_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [7:0]  header_sum, header_sum_next;
  logic [31:0] length_word, length_word_next;
  logic [15:0] block_size, block_size_next;
  logic [32:0] bytes_to_go, bytes_to_go_next;
  logic [15:0] block_fill, block_fill_next;
  logic [15:0] crc_value, crc_value_next;
  logic [7:0]  ack_char;

  logic        accept;
  logic [1:0]  res_count;
  entry_t      entry;

  // data phase helpers
  logic        store;
  logic [15:0] crc_upd;
  logic [32:0] btg_dec;
  logic [15:0] fill_inc;
  logic        have_tail;
  res_t        tail;
  res_t        store_res;

  assign in_ready  = !q_status.full;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // ack byte register, loaded on a config transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_char <= ACK_CHAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ack_char <= cfg_data;
    end
  end

  // data phase byte work
  assign store    = bytes_to_go > 33'd2;
  assign crc_upd  = crc_byte(crc_value, rx_byte);
  assign btg_dec  = (bytes_to_go != 33'd0) ? bytes_to_go - 33'd1 : bytes_to_go;
  assign fill_inc = block_fill + 16'd1;

  // next state and results of one transfer
  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    header_sum_next   = header_sum;
    length_word_next  = length_word;
    block_size_next   = block_size;
    bytes_to_go_next  = bytes_to_go;
    block_fill_next   = block_fill;
    crc_value_next    = crc_value;
    res_count         = 2'd0;
    entry             = '0;
    have_tail         = 1'b0;
    tail              = '0;
    store_res         = '0;

    unique case (cmd_t'(cmd))
      CMD_START: begin
        phase_next        = PH_HEADER;
        header_index_next = 3'd0;
        header_sum_next   = 8'd0;
        length_word_next  = 32'd0;
        block_size_next   = 16'd0;
        bytes_to_go_next  = 33'd0;
        block_fill_next   = 16'd0;
        crc_value_next    = CRC_INIT;
      end
      CMD_TIMEOUT: begin
        if (phase == PH_HEADER || phase == PH_DATA) begin
          phase_next        = PH_IDLE;
          res_count         = 2'd1;
          entry.first.kind  = KIND_TIMEOUT;
        end
      end
      CMD_BYTE: begin
        unique case (phase)
          PH_HEADER: begin
            if (header_index < 3'd4) begin
              length_word_next = length_word |
                ({24'd0, rx_byte} << {header_index[1:0], 3'b000});
              header_sum_next   = header_sum + rx_byte;
              header_index_next = header_index + 3'd1;
            end else if (header_index < 3'd6) begin
              block_size_next = block_size |
                ({8'd0, rx_byte} << {header_index[0], 3'b000});
              header_sum_next   = header_sum + rx_byte;
              header_index_next = header_index + 3'd1;
            end else begin
              header_index_next = 3'd0;
              res_count         = 2'd1;
              if (rx_byte != header_sum) begin
                phase_next       = PH_IDLE;
                entry.first.kind = KIND_CHKERR;
              end else if (block_size == 16'd0) begin
                phase_next       = PH_IDLE;
                entry.first.kind = KIND_ZEROBLK;
              end else begin
                phase_next       = PH_DATA;
                bytes_to_go_next = {1'b0, length_word} + 33'd2;
                block_fill_next  = 16'd0;
                crc_value_next   = CRC_INIT;
                entry.first.kind = KIND_ACK;
                entry.first.data = ack_char;
                entry.first.len  = length_word;
              end
            end
          end
          PH_DATA: begin
            crc_value_next   = crc_upd;
            bytes_to_go_next = btg_dec;
            block_fill_next  = fill_inc;
            store_res.kind   = KIND_STORE;
            store_res.data   = rx_byte;
            if (btg_dec == 33'd0) begin
              phase_next      = PH_IDLE;
              block_fill_next = 16'd0;
              have_tail       = 1'b1;
              tail.kind       = (crc_upd == 16'd0) ? KIND_OK : KIND_CRCERR;
            end else if (fill_inc == block_size) begin
              block_fill_next = 16'd0;
              have_tail       = 1'b1;
              tail.kind       = KIND_ACK;
              tail.data       = ack_char;
            end
            res_count    = {1'b0, store} + {1'b0, have_tail};
            entry.two    = store && have_tail;
            entry.first  = store ? store_res : tail;
            entry.second = tail;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_index <= 3'd0;
      header_sum   <= 8'd0;
      length_word  <= 32'd0;
      block_size   <= 16'd0;
      bytes_to_go  <= 33'd0;
      block_fill   <= 16'd0;
      crc_value    <= CRC_INIT;
    end else if (accept) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      header_sum   <= header_sum_next;
      length_word  <= length_word_next;
      block_size   <= block_size_next;
      bytes_to_go  <= bytes_to_go_next;
      block_fill   <= block_fill_next;
      crc_value    <= crc_value_next;
    end
  end

  // hand results to the queue
  assign push       = accept && (res_count != 2'd0);
  assign push_entry = entry;

endmodule

// File: rtl/core/brf_queue.sv
// result queue between front and back, one entry per input with results
module brf_queue #(
  parameter int DEPTH = brf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  brf_pkg::entry_t    push_entry,
  input  logic               pop,
  output brf_pkg::entry_t    head,
  output brf_pkg::q_status_t status
);
  import brf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/brf_back.sv
// back end: output register that plays out one or two results per entry
module brf_back (
  input  logic               clk,
  input  logic               rst,
  input  brf_pkg::entry_t    head,
  input  brf_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_byte,
  output logic [31:0]        file_length,
  output logic               out_last
);
  import brf_pkg::*;

  entry_t cur;
  logic   cur_valid;
  logic   sel;
  logic   done;
  res_t   shown;

  // entry finished when its last result is taken
  assign done = cur_valid && out_ready && (sel || !cur.two);
  assign pop  = !q_status.empty && (!cur_valid || done);

  // control of the output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (cur_valid && out_ready && !sel && cur.two) begin
      sel <= 1'b1;
    end else if (!cur_valid || done) begin
      cur_valid <= !q_status.empty;
      sel       <= 1'b0;
    end
  end

  // payload of the output slot
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  assign shown       = sel ? cur.second : cur.first;
  assign out_valid   = cur_valid;
  assign out_kind    = shown.kind;
  assign out_byte    = shown.data;
  assign file_length = shown.len;
  assign out_last    = sel || !cur.two;

endmodule
